// ===== rtl/mhr_pkg.sv =====
// Shared types, constants and controller state encoding for the holding register engine
package mhr_pkg;

  localparam int REQ_BUF_DEPTH_DEF = 256;
  localparam int STORE_DEPTH_DEF   = 256;

  localparam logic [8:0] LEN_SAT      = 9'd511;
  localparam logic [7:0] CAP_RESET    = 8'd253;
  localparam logic [7:0] FC_READ      = 8'h03;
  localparam logic [7:0] FC_WRITE_ONE = 8'h06;
  localparam logic [7:0] FC_WRITE_MUL = 8'h10;
  localparam logic [7:0] EXC_FUNC     = 8'h01;
  localparam logic [7:0] EXC_ADDR     = 8'h02;
  localparam logic [7:0] EXC_VALUE    = 8'h03;
  localparam logic [7:0] EXC_FLAG     = 8'h80;
  localparam logic [7:0] MAX_RD_CNT   = 8'd125;
  localparam logic [7:0] MAX_WR_CNT   = 8'd123;

  typedef enum logic [3:0] {
    ST_RECV,   // collecting request bytes
    ST_HDR,    // fetch header bytes, one per cycle
    ST_CHECK,  // validate the request
    ST_WRITE,  // walk the write registers
    ST_EMIT,   // send response chunks
    ST_DONE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic store_byte;   // transfer of a request byte
    logic clr_len;
    logic hdr_step;     // advance header fetch index
    logic hdr_clr;
    logic latch_chk;    // capture check outcome
    logic wr_step;      // one register write step
    logic emit_step;    // produce one response byte
    logic emit_init;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic hdr_done;
    logic do_write;
    logic wr_done;
    logic send;
    logic emit_done;
  } stat_t;

endpackage

// ===== rtl/mhr_ctrl.sv =====
// Controller state machine for the holding register engine
module mhr_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           req_last,
  input  mhr_pkg::stat_t stat,
  output logic           busy,
  output mhr_pkg::cmd_t  cmd
);
  import mhr_pkg::*;

  state_t state, state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_RECV;
    else state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_RECV:  if (start && req_last) state_next = ST_HDR;
      ST_HDR:   if (stat.hdr_done) state_next = ST_CHECK;
      ST_CHECK: state_next = ST_DONE;
      ST_DONE: begin
        if (stat.do_write) state_next = ST_WRITE;
        else if (stat.send) state_next = ST_EMIT;
        else state_next = ST_RECV;
      end
      ST_WRITE: if (stat.wr_done) state_next = stat.send ? ST_EMIT : ST_RECV;
      ST_EMIT:  if (stat.emit_done) state_next = ST_RECV;
      default:  state_next = ST_RECV;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    busy = (state != ST_RECV);
    case (state)
      ST_RECV: begin
        cmd.store_byte = start;
        cmd.hdr_clr = 1'b1;
      end
      ST_HDR:   cmd.hdr_step = 1'b1;
      ST_CHECK: cmd.latch_chk = 1'b1;
      ST_DONE:  cmd.emit_init = 1'b1;
      ST_WRITE: cmd.wr_step = 1'b1;
      ST_EMIT:  cmd.emit_step = 1'b1;
      default:  cmd = '0;
    endcase
    // Drop the request length only once the request is fully handled
    cmd.clr_len = (state != ST_RECV) && (state_next == ST_RECV);
  end

endmodule

// ===== rtl/mhr_dp.sv =====
// Datapath: request buffer, register store, checks and response packing
module mhr_dp #(
  parameter int REQ_BUF_DEPTH = mhr_pkg::REQ_BUF_DEPTH_DEF,
  parameter int STORE_DEPTH   = mhr_pkg::STORE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     req_byte,
  input  logic           broadcast,
  input  logic           cfg_valid,
  input  logic [7:0]     cfg_data,
  input  mhr_pkg::cmd_t  cmd,
  output mhr_pkg::stat_t stat,
  output logic [31:0]    resp_data,
  output logic [2:0]     resp_bytes,
  output logic           resp_last,
  output logic           resp_valid
);
  import mhr_pkg::*;

  localparam int BW = $clog2(REQ_BUF_DEPTH);
  localparam int SW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic [7:0]  rbuf [REQ_BUF_DEPTH];
  logic [15:0] store [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] svalid;
  logic [8:0]  len;
  logic [7:0]  capacity;
  logic        bc;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) capacity <= CAP_RESET;
    else if (cfg_valid) capacity <= cfg_data;
  end

  // Request buffer and length
  always_ff @(posedge clk) begin
    if (cmd.store_byte && (len < 9'(REQ_BUF_DEPTH))) rbuf[len[BW-1:0]] <= req_byte;
  end
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_len) len <= '0;
    else if (cmd.store_byte && len != LEN_SAT) len <= len + 9'd1;
  end
  always_ff @(posedge clk) if (cmd.store_byte) bc <= broadcast;

  // Buffer read port, registered; unused positions masked to zero
  logic [8:0] raddr;
  logic [7:0] rdata;
  logic       rok;
  always_ff @(posedge clk) begin
    rdata <= rbuf[raddr[BW-1:0]];
    rok <= (raddr < 9'(REQ_BUF_DEPTH)) && (raddr < len);
  end
  wire [7:0] rq = rok ? rdata : 8'd0;

  // Header fetch: bytes 0..5, index in hidx, data arrives in the cycle after its index
  logic [2:0] hidx;
  logic [7:0] hdr [6];
  always_ff @(posedge clk) begin
    if (cmd.hdr_clr) hidx <= '0;
    else if (cmd.hdr_step) hidx <= hidx + 3'd1;
  end
  always_ff @(posedge clk) begin
    if (cmd.hdr_step && hidx != 3'd0) hdr[hidx-3'd1] <= rq;
  end
  assign stat.hdr_done = cmd.hdr_step && (hidx == 3'd6);

  wire [7:0]  fc    = hdr[0];
  wire [15:0] saddr = {hdr[1], hdr[2]};
  wire [15:0] cnt   = {hdr[3], hdr[4]};
  wire [16:0] endad = {1'b0, saddr} + {1'b0, cnt} - 17'd1;
  wire        ovf   = endad[16];

  // Check request
  logic [7:0] r0, r1;
  logic [8:0] rlen;
  logic       wr_any, is_rd, is_echo;
  always_comb begin
    r0 = fc | EXC_FLAG; r1 = EXC_VALUE; rlen = 9'd2;
    wr_any = 1'b0; is_rd = 1'b0; is_echo = 1'b0;
    case (fc)
      FC_READ: begin
        if (bc) rlen = 9'd0;
        else if (len != 9'd5) r1 = EXC_VALUE;
        else if (cnt == 16'd0 || cnt > {8'd0, MAX_RD_CNT}) r1 = EXC_VALUE;
        else if (ovf) r1 = EXC_ADDR;
        else begin
          is_rd = 1'b1; rlen = 9'(cnt) * 9'd2 + 9'd2;
        end
      end
      FC_WRITE_ONE: begin
        if (len != 9'd5) begin
          if (bc) rlen = 9'd0;
        end else begin
          wr_any = 1'b1; is_echo = 1'b1; rlen = bc ? 9'd0 : 9'd5;
        end
      end
      FC_WRITE_MUL: begin
        if (len < 9'd6) r1 = EXC_VALUE;
        else if (cnt == 16'd0 || cnt > {8'd0, MAX_WR_CNT}) r1 = EXC_VALUE;
        else if (ovf) r1 = EXC_ADDR;
        else if ({8'd0, hdr[5]} != {cnt[14:0], 1'b0}) r1 = EXC_VALUE;
        else if ({1'b0, hdr[5]} + 9'd6 > len) r1 = EXC_VALUE;
        else begin
          wr_any = 1'b1; is_echo = 1'b1; rlen = 9'd5;
        end
        if (bc) rlen = 9'd0;
      end
      default: r1 = EXC_FUNC;
    endcase
  end

  logic [7:0] e0, e1;
  logic [8:0] elen;
  logic       dw, drd, decho, wsingle;
  logic [7:0] wcnt;
  always_ff @(posedge clk) begin
    if (cmd.latch_chk) begin
      e0 <= r0; e1 <= r1; elen <= rlen;
      dw <= wr_any; drd <= is_rd; decho <= is_echo;
      wsingle <= (fc == FC_WRITE_ONE);
      wcnt <= (fc == FC_WRITE_ONE) ? 8'd1 : cnt[7:0];
    end
  end
  wire send_w = (elen != 9'd0) && (elen <= {1'b0, capacity});
  assign stat.do_write = dw;
  assign stat.send = send_w;

  // Write walk: two buffer reads per register for the multi write, one step for the single write
  logic [7:0]  wi;
  logic        wph;
  logic [16:0] waddr;
  logic        wen;
  logic [15:0] wval;
  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      wi <= '0; wph <= 1'b0;
    end else if (cmd.wr_step) begin
      if (wsingle) wi <= wi + 8'd1;
      else begin
        wph <= ~wph;
        if (wph) wi <= wi + 8'd1;
      end
    end
  end
  assign stat.wr_done = cmd.wr_step && (wsingle || wph) &&
                        ((wi + 8'd1) == wcnt);

  // Pipeline buffer reads for the multi write
  logic p1, p2ph;
  logic [7:0] p2i;
  logic [7:0] hi_hold_b;
  always_ff @(posedge clk) begin
    if (rst) p1 <= 1'b0;
    else p1 <= cmd.wr_step && !wsingle;
    p2ph <= wph; p2i <= wi;
  end
  always_ff @(posedge clk) if (p1 && !p2ph) hi_hold_b <= rq;

  always_comb begin
    wen = 1'b0; wval = cnt; waddr = {1'b0, saddr};
    if (cmd.wr_step && wsingle) wen = 1'b1;
    else if (p1 && p2ph) begin
      wen = 1'b1; wval = {hi_hold_b, rq}; waddr = {1'b0, saddr} + {9'd0, p2i};
    end
  end

  // Register store with valid bits
  always_ff @(posedge clk) begin
    if (rst) svalid <= '0;
    else if (wen && waddr < 17'(STORE_DEPTH)) svalid[waddr[SW-1:0]] <= 1'b1;
  end
  always_ff @(posedge clk) begin
    if (wen && waddr < 17'(STORE_DEPTH)) store[waddr[SW-1:0]] <= wval;
  end

  // Emit sequencer: build each chunk byte by byte, one byte per cycle
  logic [2:0]  bj;
  logic [31:0] acc;
  logic [8:0]  bpos;
  logic [15:0] sword;
  logic        sok;
  always_comb begin
    raddr = {6'd0, hidx};
    if (cmd.wr_step) raddr = 9'd6 + {wi, 1'b0} + {8'd0, wph};
    else if (cmd.emit_step) raddr = bpos;
  end
  wire [16:0] sa = {1'b0, saddr} + {8'd0, bpos[8:1]} - 17'd1;
  always_ff @(posedge clk) begin
    sword <= store[sa[SW-1:0]];
    sok <= (sa < 17'(STORE_DEPTH)) && svalid[sa[SW-1:0]];
  end

  // byte value for position bpos-1 (fetched last cycle)
  logic [8:0] ppos;
  logic [7:0] bval;
  always_comb begin
    bval = 8'd0;
    if (decho) bval = rq;
    else if (drd) begin
      if (ppos == 9'd0) bval = FC_READ;
      else if (ppos == 9'd1) bval = elen[7:0] - 8'd2;
      else bval = !sok ? 8'd0 : (ppos[0] ? sword[7:0] : sword[15:8]);
    end else bval = (ppos == 9'd0) ? e0 : e1;
  end

  logic epipe;
  always_ff @(posedge clk) begin
    if (rst) epipe <= 1'b0;
    else epipe <= cmd.emit_step && (bpos < elen);
    ppos <= bpos;
  end
  always_ff @(posedge clk) begin
    if (cmd.emit_init) bpos <= '0;
    else if (cmd.emit_step && bpos < elen) bpos <= bpos + 9'd1;
  end

  wire last_byte = epipe && (ppos + 9'd1 == elen);
  always_ff @(posedge clk) begin
    if (cmd.emit_init) begin
      bj <= '0; acc <= '0;
    end else if (epipe) begin
      if (bj == 3'd3 || last_byte) begin
        bj <= '0; acc <= '0;
      end else begin
        bj <= bj + 3'd1; acc[31-8*bj[1:0] -: 8] <= bval;
      end
    end
  end
  logic [31:0] chunk;
  always_comb begin
    chunk = acc;
    chunk[31-8*bj[1:0] -: 8] = bval;
  end
  always_ff @(posedge clk) begin
    if (rst) resp_valid <= 1'b0;
    else resp_valid <= epipe && (bj == 3'd3 || last_byte);
    resp_data <= chunk;
    resp_bytes <= bj + 3'd1;
    resp_last <= last_byte;
  end
  assign stat.emit_done = last_byte;
endmodule

// ===== rtl/modbus_holding_register_pdu_engine_core.sv =====
// Top level of the holding register request engine
// Request bytes are taken one per cycle while busy is low. The final byte
// starts processing: the header is fetched from the request buffer, then
// checked, then dispatched. A write then stores the single register for
// function 06, or reads two buffer bytes per register for function 16. A
// response is built a byte at a time (read/echo from the request buffer and
// the register store port); its final chunk shows in the same cycle as busy
// falls. Each response chunk shows on resp_valid for one cycle; the receiver
// cannot stall. Write the capacity register only while no request is in
// flight. The register store clears at reset through valid bits, no pass.
module modbus_holding_register_pdu_engine_core #(
  parameter int REQ_BUF_DEPTH = mhr_pkg::REQ_BUF_DEPTH_DEF,
  parameter int STORE_DEPTH   = mhr_pkg::STORE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  req_byte,
  input  logic        req_last,
  input  logic        broadcast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output logic        resp_valid,
  output logic [31:0] resp_data,
  output logic [2:0]  resp_bytes,
  output logic        resp_last
);
  import mhr_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  busy_i;

  assign cfg_ready = 1'b1;
  assign busy = busy_i;

  mhr_ctrl u_ctrl (
    .clk, .rst, .start, .req_last, .stat, .busy(busy_i), .cmd
  );

  mhr_dp #(.REQ_BUF_DEPTH(REQ_BUF_DEPTH), .STORE_DEPTH(STORE_DEPTH)) u_dp (
    .clk, .rst, .req_byte, .broadcast, .cfg_valid, .cfg_data, .cmd, .stat,
    .resp_data, .resp_bytes, .resp_last, .resp_valid
  );

  // No result while a request is still being received
  assert property (@(posedge clk) disable iff (rst) resp_valid |-> $past(busy_i))
    else $error("result outside processing");
  // Chunk byte count is one to four
  assert property (@(posedge clk) disable iff (rst)
    resp_valid |-> (resp_bytes != 3'd0 && resp_bytes <= 3'd4))
    else $error("bad chunk size");
  // A non-final chunk is full
  assert property (@(posedge clk) disable iff (rst)
    (resp_valid && !resp_last) |-> resp_bytes == 3'd4)
    else $error("short inner chunk");
endmodule
